// ----- rtl/ctc_pkg.sv -----
// Shared constants, codes and types of the contingency table counter.
`timescale 1ns / 1ps
`default_nettype none
package ctc_pkg;

   localparam int MAX_VARS    = 8;
   localparam int TABLE_DEPTH = 4096;
   localparam int COUNT_BITS  = 32;
   localparam int CODE_BITS   = 4;

   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int VAR_BITS    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int NV_BITS     = $clog2(MAX_VARS + 1);
   localparam int STRIDE_BITS = ADDR_BITS + 1;
   localparam int ARITY_BITS  = CODE_BITS + 1;
   localparam int CELL_BITS   = STRIDE_BITS + ARITY_BITS;
   localparam int FIELD_BITS  = MAX_VARS * CODE_BITS;
   localparam int MASK_BITS   = MAX_VARS;

   localparam int CMD_BITS      = 2;
   localparam int STATUS_BITS   = 2;
   localparam int INDEX_BITS    = 12;
   localparam int NUM_VARS_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CMD_BITS-1:0] CMD_COUNT      = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_READ_CLEAR = 2'd2;

   localparam logic [STATUS_BITS-1:0] STAT_COUNTED = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_MISSING = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_RANGE   = 2'd2;
   localparam logic [STATUS_BITS-1:0] STAT_READ    = 2'd3;

   localparam logic REG_NUM_VARS = 1'b0;
   localparam logic REG_ARITY    = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [NUM_VARS_BITS-1:0] num_vars;
      logic [FIELD_BITS-1:0]    arity_codes;
   } cfg_type;

endpackage
`default_nettype wire

// ----- rtl/ctc_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module ctc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ----- rtl/ctc_csr.sv -----
// Configuration registers of the contingency table counter behind the APB port.
`timescale 1ns / 1ps
`default_nettype none
module ctc_csr
   import ctc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   logic [NUM_VARS_BITS-1:0] num_vars_ff, num_vars_in;
   logic [FIELD_BITS-1:0]    arity_ff, arity_in;
   logic                     wr_en;
   logic                     reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel & penable & pwrite;

   always_comb begin
      num_vars_in = num_vars_ff;
      arity_in    = arity_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_NUM_VARS: num_vars_in = pwdata[NUM_VARS_BITS-1:0];
            REG_ARITY:    arity_in    = pwdata[FIELD_BITS-1:0];
            default:      num_vars_in = num_vars_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_NUM_VARS: prdata = CSR_DATA_BITS'(num_vars_ff);
         REG_ARITY:    prdata = CSR_DATA_BITS'(arity_ff);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vars_ff <= NUM_VARS_BITS'(1);
         arity_ff    <= '0;
      end else begin
         num_vars_ff <= num_vars_in;
         arity_ff    <= arity_in;
      end
   end

   assign cfg.num_vars    = num_vars_ff;
   assign cfg.arity_codes = arity_ff;

endmodule
`default_nettype wire

// ----- rtl/contingency_table_counter_core.sv -----
// Top level: command sequencer, mixed-radix index unit and counter memory.
//
// Usage. An item is taken at a rising edge with start high and busy low.
// Command 0 counts one data case into the cell given by the mixed-radix
// index of its codes; commands 1 to 3 read one cell (2 also clears it).
// Every item yields one result, shown for a single cycle with rsp_valid
// high; the receiver cannot stall, so the result is a transfer that simply
// happens in that cycle.
// Flow: a count of n variables walks the index one variable per cycle
// through a shared multiply-add step, then does a read-modify-write on the
// counter RAM (registered read) in the update state, which registers the
// result and lets busy drop for the next item. A read goes straight to update.
// A case skipped for a missing value, or a read beyond the table, answers
// in the next cycle and busy stays low.
// Reset: the counter RAM is swept to zero one cell a cycle with busy high;
// APB writes are taken during the sweep. Configuration is to be written
// only while no item is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module contingency_table_counter_core
   import ctc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [CMD_BITS-1:0]      req_cmd,
   input  wire logic [FIELD_BITS-1:0]    req_case_values,
   input  wire logic [MASK_BITS-1:0]     req_missing_mask,
   input  wire logic [INDEX_BITS-1:0]    req_read_index,
   output logic                          rsp_valid,
   output logic      [INDEX_BITS-1:0]    rsp_cell_index,
   output logic      [COUNT_BITS-1:0]    rsp_cell_count,
   output logic      [STATUS_BITS-1:0]   rsp_status,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic [FIELD_BITS-1:0]  vals_ff, vals_in;
   logic [ADDR_BITS-1:0]   idx_ff, idx_in;
   logic [VAR_BITS-1:0]    k_ff, k_in;
   logic [STRIDE_BITS-1:0] stride_ff, stride_in;
   logic                   count_op_ff, count_op_in;
   logic                   clr_ff, clr_in;
   logic [ADDR_BITS-1:0]   clear_addr_ff, clear_addr_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]  rsp_index_ff, rsp_index_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic                   ram_we;
   logic [ADDR_BITS-1:0]   ram_waddr;
   logic [COUNT_BITS-1:0]  ram_wdata;
   logic [ADDR_BITS-1:0]   ram_raddr;
   logic [COUNT_BITS-1:0]  ram_rdata;

   logic                   accept;
   logic                   is_count;
   logic [NV_BITS-1:0]     nv_eff;
   logic [VAR_BITS-1:0]    last_k;
   logic                   miss_hit;
   logic                   read_oob;
   logic [CODE_BITS-1:0]   code;
   logic [ARITY_BITS-1:0]  arity;
   logic [CELL_BITS-1:0]   partial;
   logic [CELL_BITS-1:0]   cell_sum;
   logic [CELL_BITS-1:0]   stride_prod;
   logic [STRIDE_BITS-1:0] stride_next;
   logic                   step_bad;
   logic [COUNT_BITS-1:0]  count_inc;

   ctc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ctc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign accept   = start & (state_ff == ST_IDLE);
   assign is_count = (req_cmd == CMD_COUNT);
   assign read_oob = (int'(req_read_index) >= TABLE_DEPTH);

   // variable count clamped to 1..MAX_VARS
   always_comb begin
      if (cfg.num_vars == '0) begin
         nv_eff = NV_BITS'(1);
      end else if (int'(cfg.num_vars) > MAX_VARS) begin
         nv_eff = NV_BITS'(MAX_VARS);
      end else begin
         nv_eff = NV_BITS'(cfg.num_vars);
      end
   end

   assign last_k = VAR_BITS'(nv_eff - NV_BITS'(1));

   always_comb begin
      miss_hit = 1'b0;
      for (int k = 0; k < MAX_VARS; k++) begin
         if ((k < int'(nv_eff)) && req_missing_mask[k]) begin
            miss_hit = 1'b1;
         end
      end
   end

   // one mixed-radix step per cycle: cell += code * stride, stride *= arity
   assign code        = vals_ff[k_ff*CODE_BITS +: CODE_BITS];
   assign arity       = ARITY_BITS'(cfg.arity_codes[k_ff*CODE_BITS +: CODE_BITS])
                        + ARITY_BITS'(1);
   assign partial     = CELL_BITS'(code) * CELL_BITS'(stride_ff);
   assign cell_sum    = CELL_BITS'(idx_ff) + partial;
   assign stride_prod = CELL_BITS'(stride_ff) * CELL_BITS'(arity);
   assign stride_next = (stride_prod > CELL_BITS'(TABLE_DEPTH)) ?
                        STRIDE_BITS'(TABLE_DEPTH) : stride_prod[STRIDE_BITS-1:0];
   assign step_bad    = (ARITY_BITS'(code) >= arity) ||
                        (cell_sum >= CELL_BITS'(TABLE_DEPTH));

   assign count_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_addr_ff == ADDR_BITS'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (is_count) begin
                  state_in = miss_hit ? ST_IDLE : ST_CALC;
               end else begin
                  state_in = read_oob ? ST_IDLE : ST_UPDATE;
               end
            end
         end
         ST_CALC: begin
            if (step_bad) begin
               state_in = ST_IDLE;
            end else if (k_ff == last_k) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // memory control and handshake outputs
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = '0;
      ram_raddr = req_read_index[ADDR_BITS-1:0];
      busy      = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clear_addr_ff;
         end
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_CALC: begin
            ram_raddr = cell_sum[ADDR_BITS-1:0];
         end
         ST_UPDATE: begin
            ram_we    = count_op_ff | clr_ff;
            ram_wdata = count_op_ff ? count_inc : '0;
         end
         default: busy = 1'b1;
      endcase
   end

   // datapath
   always_comb begin
      vals_in       = vals_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      stride_in     = stride_ff;
      count_op_in   = count_op_ff;
      clr_in        = clr_ff;
      clear_addr_in = clear_addr_ff;
      rsp_valid_in  = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + ADDR_BITS'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               vals_in     = req_case_values;
               count_op_in = is_count;
               clr_in      = (req_cmd == CMD_READ_CLEAR);
               k_in        = '0;
               stride_in   = STRIDE_BITS'(1);
               idx_in      = is_count ? '0 : req_read_index[ADDR_BITS-1:0];
               if (is_count && miss_hit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_index_in  = '0;
                  rsp_count_in  = '0;
                  rsp_status_in = STAT_MISSING;
               end else if (!is_count && read_oob) begin
                  rsp_valid_in  = 1'b1;
                  rsp_index_in  = req_read_index;
                  rsp_count_in  = '0;
                  rsp_status_in = STAT_RANGE;
               end
            end
         end
         ST_CALC: begin
            if (step_bad) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = '0;
               rsp_count_in  = '0;
               rsp_status_in = STAT_RANGE;
            end else begin
               idx_in    = cell_sum[ADDR_BITS-1:0];
               stride_in = stride_next;
               k_in      = k_ff + VAR_BITS'(1);
            end
         end
         ST_UPDATE: begin
            rsp_valid_in  = 1'b1;
            rsp_index_in  = INDEX_BITS'(idx_ff);
            rsp_count_in  = count_op_ff ? count_inc : ram_rdata;
            rsp_status_in = count_op_ff ? STAT_COUNTED : STAT_READ;
         end
         default: rsp_valid_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         k_ff          <= '0;
         count_op_ff   <= 1'b0;
         clr_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         k_ff          <= k_in;
         count_op_ff   <= count_op_in;
         clr_ff        <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      vals_ff       <= vals_in;
      idx_ff        <= idx_in;
      stride_ff     <= stride_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_index = rsp_index_ff;
   assign rsp_cell_count = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

`ifndef SYNTHESIS
   a_we_only_clear_or_update: assert property (@(posedge clock)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_UPDATE))
      else $error("counter RAM written outside sweep or update");

   a_update_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> rsp_valid_ff)
      else $error("update cycle did not produce a result");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_COUNTED) |-> (rsp_count_ff != '0))
      else $error("counted result carries a zero count");

   a_no_result_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clearing sweep");
`endif

endmodule
`default_nettype wire
